>>> rtl/swk_pkg.sv
// ---------------------------------------------------------------------------
// swk_pkg
// Shared constants, the CORDIC arctangent table and the fixed-point helpers
// of the swerve wheel kinematics core.
// ---------------------------------------------------------------------------
package swk_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CORDIC_STAGES_MAX = 24;

	localparam int CMD_W   = 16;	// Q1.14 command
	localparam int SQ_W    = 18;	// command after optional signed square
	localparam int ROT_W   = 36;	// rotator datapath, 16 guard bits
	localparam int ZR_W    = 34;	// rotator residual angle
	localparam int RW_W    = 20;	// rot * ratio product
	localparam int FS_W    = 20;	// robot-frame forward / strafe
	localparam int TERM_W  = 21;	// swerve terms A..D
	localparam int VEC_W   = 40;	// vectoring datapath, 16 guard bits
	localparam int SQRT_BITS = 17;
	localparam int SPEED_W = 17;
	localparam int ANGLE_W = 16;

	localparam logic [15:0] GAIN_INV = 16'd39797;	// 1/K in Q0.16
	localparam logic [15:0] RATIO_RST = 16'd11585;

	typedef enum logic [2:0] {
		CFG_SQ_TRANS = 3'd0,
		CFG_SQ_ROT   = 3'd1,
		CFG_VEL_MODE = 3'd2,
		CFG_WB_RATIO = 3'd3,
		CFG_TW_RATIO = 3'd4
	} cfg_idx_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] v;
		case (i)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051E;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// (x*x + 2^13) >> 14 with the sign of x put back
	function automatic logic signed [SQ_W-1:0] sq_keep_sign(
		input logic signed [CMD_W-1:0] x);
		logic signed [31:0] p;
		logic [31:0] r;
		logic [SQ_W-1:0] m;
		p = x * x;
		r = p + 32'sd8192;
		m = r[31:14];
		return x[CMD_W-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic int wheel_latency(input int ns);
		int ls;
		int la;
		ls = SQRT_BITS + 2;
		la = ns + 2;
		return (ls > la) ? ls : la;
	endfunction

endpackage

>>> rtl/swk_wheel.sv
// ---------------------------------------------------------------------------
// swk_wheel
// One wheel: speed = floor(hypot(ty, tx)) saturating, and steering angle
// atan2(ty, tx) as a binary angle. Both paths are padded to the same depth.
// ---------------------------------------------------------------------------
module swk_wheel #(
	parameter int NS = swk_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [swk_pkg::TERM_W-1:0]     ty,
	input  logic signed [swk_pkg::TERM_W-1:0]     tx,
	output logic        [swk_pkg::SPEED_W-1:0]    speed,
	output logic        [swk_pkg::ANGLE_W-1:0]    angle
);
	localparam int TW = swk_pkg::TERM_W;
	localparam int VW = swk_pkg::VEC_W;
	localparam int SB = swk_pkg::SQRT_BITS;
	localparam int WL = swk_pkg::wheel_latency(NS);
	localparam int LS = SB + 2;
	localparam int LA = NS + 2;
	localparam int PAD_S = WL - LS;
	localparam int PAD_A = WL - LA;

	// ---------------- speed: squares, sum, digit-by-digit root ------------
	logic signed [2*TW-1:0] prod_y, prod_x;
	logic [2*TW-2:0] py2_s1, px2_s1;
	logic [2*SB:0]   rem_s  [0:SB];
	logic [SB-1:0]   root_s [0:SB];
	logic            sat_s  [0:SB];
	logic [2*TW-1:0] sum2;
	logic [swk_pkg::SPEED_W-1:0] speed_pre;

	assign prod_y = ty * ty;
	assign prod_x = tx * tx;
	assign sum2 = {1'b0, py2_s1} + {1'b0, px2_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			py2_s1    <= prod_y[2*TW-2:0];
			px2_s1    <= prod_x[2*TW-2:0];
			rem_s[0]  <= {1'b0, sum2[2*SB-1:0]};
			root_s[0] <= '0;
			sat_s[0]  <= |sum2[2*TW-1:2*SB];
		end
	end

	for (genvar k = 0; k < SB; k++) begin : g_sqrt
		localparam int J = SB - 1 - k;
		logic [2*SB+1:0] cand;
		logic            ge;
		assign cand = ((2*SB+2)'({root_s[k], 1'b0}) | ((2*SB+2)'(1) << J)) << J;
		assign ge = {1'b0, rem_s[k]} >= cand;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? rem_s[k] - cand[2*SB:0] : rem_s[k];
				root_s[k+1] <= ge ? (root_s[k] | (SB'(1) << J)) : root_s[k];
				sat_s[k+1]  <= sat_s[k];
			end
		end
	end

	assign speed_pre = sat_s[SB] ? '1 : root_s[SB];

	// ---------------- angle: CORDIC vectoring ------------------------------
	logic signed [VW-1:0] vx_s [0:NS];
	logic signed [VW-1:0] vy_s [0:NS];
	logic [31:0]          vz_s [0:NS];
	logic                 zero_s [0:NS];
	logic [swk_pkg::ANGLE_W-1:0] ang_s;
	logic signed [VW-1:0] x_ext, y_ext;
	logic [31:0] z_rnd;

	assign x_ext = {{(VW-TW-16){tx[TW-1]}}, tx, 16'b0};
	assign y_ext = {{(VW-TW-16){ty[TW-1]}}, ty, 16'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			// half-turn pre-rotation keeps x nonnegative
			vx_s[0]   <= tx[TW-1] ? -x_ext : x_ext;
			vy_s[0]   <= tx[TW-1] ? -y_ext : y_ext;
			vz_s[0]   <= tx[TW-1] ? 32'h80000000 : 32'h0;
			zero_s[0] <= (tx == '0) && (ty == '0);
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				if (!vy_s[i][VW-1]) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + swk_pkg::atan_turn(i);
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - swk_pkg::atan_turn(i);
				end
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	assign z_rnd = vz_s[NS] + 32'h8000;

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s <= zero_s[NS] ? '0 : z_rnd[31:16];
		end
	end

	// ---------------- depth alignment ---------------------------------------
	if (PAD_S > 0) begin : g_pad_s
		logic [swk_pkg::SPEED_W-1:0] spd_dly_s [0:PAD_S-1];
		always_ff @(posedge clk) begin
			if (en) begin
				spd_dly_s[0] <= speed_pre;
				for (int n = 1; n < PAD_S; n++) spd_dly_s[n] <= spd_dly_s[n-1];
			end
		end
		assign speed = spd_dly_s[PAD_S-1];
	end else begin : g_nopad_s
		assign speed = speed_pre;
	end

	if (PAD_A > 0) begin : g_pad_a
		logic [swk_pkg::ANGLE_W-1:0] ang_dly_s [0:PAD_A-1];
		always_ff @(posedge clk) begin
			if (en) begin
				ang_dly_s[0] <= ang_s;
				for (int n = 1; n < PAD_A; n++) ang_dly_s[n] <= ang_dly_s[n-1];
			end
		end
		assign angle = ang_dly_s[PAD_A-1];
	end else begin : g_nopad_a
		assign angle = ang_s;
	end

endmodule

>>> rtl/swerve_wheel_kinematics_core.sv
// CORDIC_STAGES values above 24 are capped at 24.
// Throughput: one beat per cycle; every stage is a register and the whole
//   pipe advances unless the output register holds an untaken beat.
// Reset (arst_n low) empties the pipe and loads the register defaults.
// ---------------------------------------------------------------------------
// swerve_wheel_kinematics_core
// Swerve inverse kinematics: optional signed squaring, CORDIC field-to-robot
// rotation, swerve terms, and per-wheel speed and steering angle.
// ---------------------------------------------------------------------------
module swerve_wheel_kinematics_core #(
	parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// forward_cmd, strafe_cmd, rotate_cmd, heading
	input  logic [63:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// speed_front_right, speed_front_left, speed_rear_left, speed_rear_right,
	// angle_front_right, angle_front_left, angle_rear_left, angle_rear_right
	output logic [135:0] m_tdata,
	// module_velocity_mode
	output logic         m_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	localparam int NS = (CORDIC_STAGES > swk_pkg::CORDIC_STAGES_MAX) ?
		swk_pkg::CORDIC_STAGES_MAX : CORDIC_STAGES;
	localparam int WL = swk_pkg::wheel_latency(NS);
	localparam int DEPTH = NS + 4 + WL;
	localparam int SQ = swk_pkg::SQ_W;
	localparam int RW = swk_pkg::ROT_W;
	localparam int ZW = swk_pkg::ZR_W;
	localparam int PW = swk_pkg::RW_W;
	localparam int FW = swk_pkg::FS_W;
	localparam int TW = swk_pkg::TERM_W;

	// ---------------- configuration ----------------------------------------
	logic        sq_trans_q, sq_rot_q, vel_mode_q;
	logic [15:0] wb_ratio_q, tw_ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_trans_q <= 1'b0;
			sq_rot_q   <= 1'b0;
			vel_mode_q <= 1'b0;
			wb_ratio_q <= swk_pkg::RATIO_RST;
			tw_ratio_q <= swk_pkg::RATIO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				swk_pkg::CFG_SQ_TRANS: sq_trans_q <= cfg_data[0];
				swk_pkg::CFG_SQ_ROT:   sq_rot_q   <= cfg_data[0];
				swk_pkg::CFG_VEL_MODE: vel_mode_q <= cfg_data[0];
				swk_pkg::CFG_WB_RATIO: wb_ratio_q <= cfg_data;
				swk_pkg::CFG_TW_RATIO: tw_ratio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- flow control -----------------------------------------
	logic             en;
	logic [DEPTH-1:0] vld_q;

	assign en       = m_tready | ~m_tvalid;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
	end

	// ---------------- stage 1: squaring, heading split ---------------------
	logic signed [15:0]   fin, sin, rin;
	logic [15:0]          hd, hd_rnd;
	logic signed [SQ-1:0] f_s1, s_s1, r_s1;
	logic [1:0]           q_s1;
	logic signed [15:0]   res_s1;

	assign fin    = s_tdata[15:0];
	assign sin    = s_tdata[31:16];
	assign rin    = s_tdata[47:32];
	assign hd     = s_tdata[63:48];
	assign hd_rnd = hd + 16'd8192;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= sq_trans_q ? swk_pkg::sq_keep_sign(fin) : SQ'(fin);
			s_s1   <= sq_trans_q ? swk_pkg::sq_keep_sign(sin) : SQ'(sin);
			r_s1   <= sq_rot_q   ? swk_pkg::sq_keep_sign(rin) : SQ'(rin);
			q_s1   <= hd_rnd[15:14];
			res_s1 <= hd - {hd_rnd[15:14], 14'b0};
		end
	end

	// ---------------- stage 2: quarter-turn, ratio products ----------------
	logic signed [RW-1:0] fx, sy;
	logic signed [ZW-1:0] z_res;
	logic signed [SQ+16:0] rwp, rtp;

	assign fx    = {{(RW-SQ-16){f_s1[SQ-1]}}, f_s1, 16'b0};
	assign sy    = {{(RW-SQ-16){s_s1[SQ-1]}}, s_s1, 16'b0};
	assign z_res = {{(ZW-32){res_s1[15]}}, res_s1, 16'b0};
	assign rwp   = r_s1 * $signed({1'b0, wb_ratio_q}) + (SQ+17)'(8192);
	assign rtp   = r_s1 * $signed({1'b0, tw_ratio_q}) + (SQ+17)'(8192);

	logic signed [RW-1:0] rx_s  [0:NS];
	logic signed [RW-1:0] ry_s  [0:NS];
	logic signed [ZW-1:0] rz_s  [0:NS];
	logic signed [PW-1:0] rwb_s [0:NS];
	logic signed [PW-1:0] rtw_s [0:NS];

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s1)
				2'd1: begin rx_s[0] <= sy;  ry_s[0] <= -fx; end
				2'd2: begin rx_s[0] <= -fx; ry_s[0] <= -sy; end
				2'd3: begin rx_s[0] <= -sy; ry_s[0] <= fx;  end
				default: begin rx_s[0] <= fx; ry_s[0] <= sy; end
			endcase
			rz_s[0]  <= -z_res;
			rwb_s[0] <= rwp[PW+13:14];
			rtw_s[0] <= rtp[PW+13:14];
		end
	end

	// ---------------- rotation stages --------------------------------------
	for (genvar i = 0; i < NS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (!rz_s[i][ZW-1]) begin
					rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
					rz_s[i+1] <= rz_s[i] - $signed({2'b00, swk_pkg::atan_turn(i)});
				end else begin
					rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
					rz_s[i+1] <= rz_s[i] + $signed({2'b00, swk_pkg::atan_turn(i)});
				end
				rwb_s[i+1] <= rwb_s[i];
				rtw_s[i+1] <= rtw_s[i];
			end
		end
	end

	// ---------------- gain removal -----------------------------------------
	logic signed [RW+16:0] gx, gy;
	logic signed [FW-1:0]  fwd_s3, str_s3;
	logic signed [PW-1:0]  rwb_s3, rtw_s3;

	assign gx = rx_s[NS] * $signed({1'b0, swk_pkg::GAIN_INV}) + ((RW+17)'(1) <<< 31);
	assign gy = ry_s[NS] * $signed({1'b0, swk_pkg::GAIN_INV}) + ((RW+17)'(1) <<< 31);

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_s3 <= gx[FW+31:32];
			str_s3 <= gy[FW+31:32];
			rwb_s3 <= rwb_s[NS];
			rtw_s3 <= rtw_s[NS];
		end
	end

	// ---------------- swerve terms -----------------------------------------
	logic signed [TW-1:0] ta_s4, tb_s4, tc_s4, td_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s4 <= TW'(str_s3) - TW'(rwb_s3);
			tb_s4 <= TW'(str_s3) + TW'(rwb_s3);
			tc_s4 <= TW'(fwd_s3) - TW'(rtw_s3);
			td_s4 <= TW'(fwd_s3) + TW'(rtw_s3);
		end
	end

	// ---------------- wheels -----------------------------------------------
	logic [16:0] spd_fr, spd_fl, spd_rl, spd_rr;
	logic [15:0] ang_fr, ang_fl, ang_rl, ang_rr;

	swk_wheel #(.NS(NS)) u_fr (.clk(clk), .en(en), .ty(tb_s4), .tx(tc_s4),
		.speed(spd_fr), .angle(ang_fr));
	swk_wheel #(.NS(NS)) u_fl (.clk(clk), .en(en), .ty(tb_s4), .tx(td_s4),
		.speed(spd_fl), .angle(ang_fl));
	swk_wheel #(.NS(NS)) u_rl (.clk(clk), .en(en), .ty(ta_s4), .tx(td_s4),
		.speed(spd_rl), .angle(ang_rl));
	swk_wheel #(.NS(NS)) u_rr (.clk(clk), .en(en), .ty(ta_s4), .tx(tc_s4),
		.speed(spd_rr), .angle(ang_rr));

	assign m_tdata = {4'b0, ang_rr, ang_rl, ang_fl, ang_fr,
		spd_rr, spd_rl, spd_fl, spd_fr};
	// the user changes the mode only while idle; the block does not enforce it
	assign m_tuser = vel_mode_q;

endmodule

>>> rtl/swk_checker.sv
// ---------------------------------------------------------------------------
// swk_assert_chk
// Port-level checks of the swerve wheel kinematics core, bound to the top.
// ---------------------------------------------------------------------------
module swk_assert_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata,
	input logic         m_tuser,
	input logic         cfg_we
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output is stalled");

	// valid bits are cleared asynchronously by reset; checked while reset is held
	a_reset_empty: assert property (@(posedge clk)
		!arst_n ##1 !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	a_mode_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(m_tuser))
		else $error("mode flag moved without a register write");

endmodule

bind swerve_wheel_kinematics_core swk_assert_chk u_swk_checker (.*);
